[sv/tcb_pkg.sv]
`timescale 1ns / 1ps

package tcb_pkg;

    localparam int RECORDS          = 1024;
    localparam int WORDS_PER_RECORD = 4;

    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 11;
    localparam int DECIM_W   = 16;
    localparam int REC_IDX_W = 16;
    localparam int WRD_IDX_W = 8;
    localparam int TTYPE_W   = 3;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int REC_AW   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int WSEL_W   = (WORDS_PER_RECORD > 1) ? $clog2(WORDS_PER_RECORD) : 1;
    localparam int ROW_W    = WORDS_PER_RECORD * WORD_W;

    localparam int S_DATA_W = 256;
    localparam int M_DATA_W = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRIGGER = 3'd0,
        KIND_SAMPLE  = 3'd1,
        KIND_START   = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_READ    = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_TYPE  = 2'd0,
        CFG_TRIGGER_VALUE = 2'd1,
        CFG_SAMPLE_DELAY  = 2'd2
    } cfg_index_t;

    localparam logic [TTYPE_W-1:0] TRIG_POS_LT = 3'd1;
    localparam logic [TTYPE_W-1:0] TRIG_POS_GT = 3'd2;
    localparam logic [TTYPE_W-1:0] TRIG_VEL_LT = 3'd3;
    localparam logic [TTYPE_W-1:0] TRIG_VEL_GT = 3'd4;
    localparam logic [TTYPE_W-1:0] TRIG_TRQ_LT = 3'd5;
    localparam logic [TTYPE_W-1:0] TRIG_TRQ_GT = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_REC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_WRD = 2'd2;

    localparam logic [DECIM_W-1:0] DECIM_MAX = {DECIM_W{1'b1}};

endpackage

[sv/triggered_capture_buffer.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// s_axis    in         s_tvalid / s_tready      s_tdata: one command transaction
// m_axis    out        m_tvalid / m_tready      m_tdata: one result transaction
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data: register write
//
// One transaction per cycle is accepted while the output does not stall; its result passes
// through the registered read of the record memory and then through the output register.
// The trace memory holds one full record per row, so a sample is stored in one write.
// Reset is synchronous and clears the flags, the counters and the pipeline valids.
// A stalled output holds its transaction and back-pressure reaches s_tready after one stage.
module triggered_capture_buffer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // kind, torque, velocity, position, word_0, word_1, word_2, word_3,
    // record_index, word_index
    input  logic [tcb_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_word, read_status, recording, armed, stored_count
    output logic [tcb_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tcb_pkg::*;

    logic [ROW_W-1:0] mem [RECORDS];

    logic [TTYPE_W-1:0]       ttype_reg;
    logic signed [WORD_W-1:0] tvalue_reg;
    logic [DECIM_W-1:0]       delay_reg;

    logic               recording_reg, recording_next;
    logic               armed_reg, armed_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DECIM_W-1:0] decim_reg, decim_next;

    logic                s1_valid_reg;
    logic                s1_ok_reg;
    logic [WSEL_W-1:0]   s1_wsel_reg;
    logic [STATUS_W-1:0] s1_status_reg;
    logic                s1_rec_reg;
    logic                s1_arm_reg;
    logic [COUNT_W-1:0]  s1_cnt_reg;
    logic [ROW_W-1:0]    rd_row_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    kind_t                    kind;
    logic signed [WORD_W-1:0] torque, velocity, position;
    logic [ROW_W-1:0]         row_in;
    logic [REC_IDX_W-1:0]     rec_idx;
    logic [WRD_IDX_W-1:0]     wrd_idx;

    logic                s_accept, advance, fires, store, do_read;
    logic [STATUS_W-1:0] status;
    logic [DECIM_W-1:0]  decim_inc;
    logic [WORD_W-1:0]   rd_word;

    assign kind     = kind_t'(s_tdata[2:0]);
    assign torque   = s_tdata[34:3];
    assign velocity = s_tdata[66:35];
    assign position = s_tdata[98:67];
    assign row_in   = s_tdata[98 + ROW_W:99];
    assign rec_idx  = s_tdata[242:227];
    assign wrd_idx  = s_tdata[250:243];

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttype_reg  <= '0;
            tvalue_reg <= '0;
            delay_reg  <= DECIM_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_TRIGGER_TYPE:  ttype_reg  <= cfg_data[TTYPE_W-1:0];
                CFG_TRIGGER_VALUE: tvalue_reg <= cfg_data[WORD_W-1:0];
                CFG_SAMPLE_DELAY:  delay_reg  <= cfg_data[DECIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ttype_reg)
            TRIG_POS_LT: fires = position < tvalue_reg;
            TRIG_POS_GT: fires = position > tvalue_reg;
            TRIG_VEL_LT: fires = velocity < tvalue_reg;
            TRIG_VEL_GT: fires = velocity > tvalue_reg;
            TRIG_TRQ_LT: fires = torque < tvalue_reg;
            TRIG_TRQ_GT: fires = torque > tvalue_reg;
            default:     fires = 1'b1;
        endcase
    end

    assign decim_inc = (decim_reg < DECIM_MAX) ? decim_reg + DECIM_W'(1) : decim_reg;

    always_comb begin
        recording_next = recording_reg;
        armed_next     = armed_reg;
        count_next     = count_reg;
        decim_next     = decim_reg;
        store          = 1'b0;
        do_read        = 1'b0;
        status         = STATUS_OK;
        case (kind)
            KIND_TRIGGER: begin
                if (armed_reg && fires) begin
                    recording_next = 1'b1;
                    armed_next     = 1'b0;
                end
            end
            KIND_SAMPLE: begin
                decim_next = decim_inc;
                if (decim_inc >= delay_reg && recording_reg
                        && 32'(count_reg) < RECORDS) begin
                    store      = 1'b1;
                    decim_next = '0;
                    count_next = count_reg + COUNT_W'(1);
                    if (32'(count_reg) + 32'd1 == RECORDS) begin
                        recording_next = 1'b0;
                        armed_next     = 1'b0;
                        count_next     = '0;
                    end
                end
            end
            KIND_START: begin
                recording_next = 1'b0;
                armed_next     = 1'b1;
                count_next     = '0;
            end
            KIND_STOP: begin
                recording_next = 1'b0;
                armed_next     = 1'b0;
                count_next     = '0;
            end
            KIND_READ: begin
                if (32'(rec_idx) >= RECORDS) begin
                    status = STATUS_BAD_REC;
                end else if (32'(wrd_idx) >= WORDS_PER_RECORD) begin
                    status = STATUS_BAD_WRD;
                end else begin
                    do_read = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept && store) begin
            mem[count_reg[REC_AW-1:0]] <= row_in;
        end
        if (s_accept && do_read) begin
            rd_row_reg <= mem[rec_idx[REC_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recording_reg <= 1'b0;
            armed_reg     <= 1'b0;
            count_reg     <= '0;
            decim_reg     <= '0;
        end else if (s_accept) begin
            recording_reg <= recording_next;
            armed_reg     <= armed_next;
            count_reg     <= count_next;
            decim_reg     <= decim_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s_accept) begin
            s1_ok_reg     <= do_read;
            s1_wsel_reg   <= wrd_idx[WSEL_W-1:0];
            s1_status_reg <= status;
            s1_rec_reg    <= recording_next;
            s1_arm_reg    <= armed_next;
            s1_cnt_reg    <= count_next;
        end
    end

    always_comb begin
        rd_word = rd_row_reg[WORD_W-1:0];
        for (int i = 0; i < WORDS_PER_RECORD; i++) begin
            if (WSEL_W'(i) == s1_wsel_reg) begin
                rd_word = rd_row_reg[i*WORD_W +: WORD_W];
            end
        end
        if (!s1_ok_reg) begin
            rd_word = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
        if (advance && s1_valid_reg) begin
            m_data_reg <= {1'b0, s1_cnt_reg, s1_arm_reg, s1_rec_reg, s1_status_reg, rd_word};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(armed_reg && recording_reg))
        else $error("armed and recording are both set");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) < RECORDS)
        else $error("record count reached the buffer size");

    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !recording_reg |-> count_reg == '0)
        else $error("record count is nonzero outside a capture");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted transaction did not enter the read stage");

    a_store_only_recording: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && store) |-> recording_reg)
        else $error("record stored outside a capture");

endmodule

[verif/tb_triggered_capture_buffer.sv]
`timescale 1ns / 1ps

module tb_triggered_capture_buffer;
    import tcb_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [WRD_IDX_W-1:0]              wrd_idx;
        logic [REC_IDX_W-1:0]              rec_idx;
        logic [3:0][WORD_W-1:0]            words;
        logic [WORD_W-1:0]                 position;
        logic [WORD_W-1:0]                 velocity;
        logic [WORD_W-1:0]                 torque;
        logic [KIND_W-1:0]                 kind;
    } command_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  stored_count;
        logic                armed;
        logic                recording;
        logic [STATUS_W-1:0] read_status;
        logic [WORD_W-1:0]   read_word;
    } report_t;

    class capture_scoreboard;
        logic [WORD_W-1:0]        store_words [RECORDS*WORDS_PER_RECORD];
        bit                       rec_on;
        bit                       arm_on;
        int unsigned              rec_cnt;
        int unsigned              decim;
        logic [TTYPE_W-1:0]       ttype;
        logic signed [WORD_W-1:0] tval;
        logic [DECIM_W-1:0]       sdelay;
        int unsigned              hi_written;
        report_t                  due_reports [$];
        int unsigned              mismatches;
        int unsigned              checked;
        int unsigned              stores;
        int unsigned              full_stops;
        int unsigned              trigger_hits;

        function new();
            rec_on = 0;
            arm_on = 0;
            rec_cnt = 0;
            decim = 0;
            ttype = '0;
            tval = '0;
            sdelay = DECIM_W'(1);
            hi_written = 0;
            mismatches = 0;
            checked = 0;
            stores = 0;
            full_stops = 0;
            trigger_hits = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_TRIGGER_TYPE:  ttype = v[TTYPE_W-1:0];
                CFG_TRIGGER_VALUE: tval = v;
                CFG_SAMPLE_DELAY:  sdelay = v[DECIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void halt();
            rec_on = 0;
            arm_on = 0;
            rec_cnt = 0;
        endfunction

        function bit fires(command_t c);
            case (ttype)
                TRIG_POS_LT: return $signed(c.position) < tval;
                TRIG_POS_GT: return $signed(c.position) > tval;
                TRIG_VEL_LT: return $signed(c.velocity) < tval;
                TRIG_VEL_GT: return $signed(c.velocity) > tval;
                TRIG_TRQ_LT: return $signed(c.torque) < tval;
                TRIG_TRQ_GT: return $signed(c.torque) > tval;
                default:     return 1'b1;
            endcase
        endfunction

        function void note_command(command_t c);
            report_t     e;
            int unsigned base;
            e = '0;
            case (c.kind)
                KIND_TRIGGER: begin
                    if (arm_on && fires(c)) begin
                        rec_on = 1;
                        arm_on = 0;
                        trigger_hits++;
                    end
                end
                KIND_SAMPLE: begin
                    if (decim < DECIM_MAX)
                        decim++;
                    if (decim >= sdelay && rec_on && rec_cnt < RECORDS) begin
                        base = rec_cnt * WORDS_PER_RECORD;
                        for (int j = 0; j < WORDS_PER_RECORD; j++)
                            store_words[base + j] = c.words[j];
                        rec_cnt++;
                        stores++;
                        if (rec_cnt > hi_written)
                            hi_written = rec_cnt;
                        decim = 0;
                        if (rec_cnt == RECORDS) begin
                            halt();
                            full_stops++;
                        end
                    end
                end
                KIND_START: begin
                    rec_on = 0;
                    arm_on = 1;
                    rec_cnt = 0;
                end
                KIND_STOP: halt();
                KIND_READ: begin
                    if (c.rec_idx >= RECORDS)
                        e.read_status = STATUS_BAD_REC;
                    else if (c.wrd_idx >= WORDS_PER_RECORD)
                        e.read_status = STATUS_BAD_WRD;
                    else
                        e.read_word = store_words[int'(c.rec_idx) * WORDS_PER_RECORD
                                                  + int'(c.wrd_idx)];
                end
                default: ;
            endcase
            e.recording = rec_on;
            e.armed = arm_on;
            e.stored_count = rec_cnt[COUNT_W-1:0];
            due_reports.push_back(e);
        endfunction

        function void check_report(report_t got);
            report_t e;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Unexpected result transaction: word=%h status=%0d",
                              " rec=%b arm=%b count=%0d"},
                             got.read_word, got.read_status, got.recording, got.armed,
                             got.stored_count);
                return;
            end
            e = due_reports.pop_front();
            checked++;
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected word=%h status=%0d rec=%b arm=%b count=%0d,",
                              " got word=%h status=%0d rec=%b arm=%b count=%0d"},
                             e.read_word, e.read_status, e.recording, e.armed, e.stored_count,
                             got.read_word, got.read_status, got.recording, got.armed,
                             got.stored_count);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    capture_scoreboard sb;
    int unsigned       items_sent = 0;
    bit                calm = 0;
    bit                hold_off_req = 0;

    triggered_capture_buffer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic command_t fresh(logic [KIND_W-1:0] k);
        command_t c;
        c.kind = k;
        c.torque = $urandom;
        c.velocity = $urandom;
        c.position = $urandom;
        for (int j = 0; j < 4; j++)
            c.words[j] = $urandom;
        c.rec_idx = REC_IDX_W'($urandom);
        c.wrd_idx = WRD_IDX_W'($urandom);
        return c;
    endfunction

    function automatic command_t read_at(int unsigned rec, int unsigned wrd);
        command_t c;
        c = fresh(KIND_READ);
        c.rec_idx = rec[REC_IDX_W-1:0];
        c.wrd_idx = wrd[WRD_IDX_W-1:0];
        return c;
    endfunction

    // Valid reads only touch records that some capture has written.
    function automatic command_t read_cmd();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6 && sb.hi_written > 0)
            return read_at($urandom_range(0, sb.hi_written - 1),
                           $urandom_range(0, WORDS_PER_RECORD - 1));
        else if (r < 8)
            return read_at($urandom_range(RECORDS, 65535), $urandom_range(0, 255));
        else
            return read_at($urandom_range(0, RECORDS - 1),
                           $urandom_range(WORDS_PER_RECORD, 255));
    endfunction

    function automatic logic [WORD_W-1:0] probe_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return sb.tval;
            2:       return sb.tval + $urandom_range(0, 4) - 2;
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic command_t trigger_cmd();
        command_t c;
        c = fresh(KIND_TRIGGER);
        c.torque = probe_value();
        c.velocity = probe_value();
        c.position = probe_value();
        return c;
    endfunction

    task automatic send_item(command_t c);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W - $bits(command_t)){1'b0}}, c};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(c);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic configure(logic [TTYPE_W-1:0] t, logic [WORD_W-1:0] v,
                             logic [DECIM_W-1:0] d);
        cfg_index_t            idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_TRIGGER_TYPE;
        idx[1] = CFG_TRIGGER_VALUE;
        idx[2] = CFG_SAMPLE_DELAY;
        val[0] = $urandom;
        val[0][TTYPE_W-1:0] = t;
        val[1] = v;
        val[2] = $urandom;
        val[2][DECIM_W-1:0] = d;
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.due_reports.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned stop_at;
        int unsigned n;
        int unsigned k;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 70) begin
                send_item(fresh(KIND_START));
                n = $urandom_range(1, 4);
                repeat (n) send_item(trigger_cmd());
                n = $urandom_range(2, 16);
                repeat (n) begin
                    k = $urandom_range(0, 19);
                    if (k < 14)
                        send_item(fresh(KIND_SAMPLE));
                    else if (k < 17)
                        send_item(read_cmd());
                    else if (k < 19)
                        send_item(trigger_cmd());
                    else
                        send_item(fresh(KIND_STOP));
                end
            end else begin
                k = $urandom_range(0, 7);
                if (k == KIND_READ)
                    send_item(read_cmd());
                else
                    send_item(fresh(k[KIND_W-1:0]));
            end
        end
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_report(report_t'(m_tdata[$bits(report_t)-1:0]));
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles.", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        command_t          c;
        logic [WORD_W-1:0] v;
        logic [DECIM_W-1:0] d;
        sb = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset register values first: type always, threshold zero, delay one.
        send_item(read_at(RECORDS, 0));
        send_item(read_at(65535, 255));
        send_item(read_at(0, WORDS_PER_RECORD));
        send_item(read_at(RECORDS - 1, 255));
        send_item(fresh(3'd5));
        send_item(fresh(3'd6));
        send_item(fresh(3'd7));
        send_item(fresh(KIND_TRIGGER));
        send_item(fresh(KIND_SAMPLE));
        send_item(fresh(KIND_STOP));
        send_item(fresh(KIND_START));
        c = fresh(KIND_TRIGGER);
        c.torque = 32'h8000_0000;
        c.velocity = 32'h7FFF_FFFF;
        c.position = '0;
        send_item(c);
        c = fresh(KIND_SAMPLE);
        c.words = {32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_item(c);
        c.words = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        send_item(c);
        for (int w = 0; w < WORDS_PER_RECORD; w++)
            send_item(read_at(0, w));
        send_item(read_at(1, WORDS_PER_RECORD - 1));
        send_item(fresh(KIND_START));
        send_item(fresh(KIND_TRIGGER));
        send_item(fresh(KIND_STOP));
        send_item(fresh(KIND_TRIGGER));
        settle();

        // Fill the whole buffer in one capture so that it stops by itself.
        configure(3'd7, $urandom, 16'd0);
        send_item(fresh(KIND_START));
        send_item(fresh(KIND_TRIGGER));
        for (int i = 0; i < RECORDS + 8; i++) begin
            send_item(fresh(KIND_SAMPLE));
            if (i % 37 == 0)
                send_item(read_cmd());
        end
        send_item(read_at(RECORDS - 1, WORDS_PER_RECORD - 1));
        settle();

        // Capture at the largest delay, which no sample of this run reaches.
        configure(3'd0, 32'h0, 16'hFFFF);
        send_item(fresh(KIND_STOP));
        repeat (6) send_item(fresh(KIND_SAMPLE));
        send_item(fresh(KIND_START));
        send_item(fresh(KIND_TRIGGER));
        send_item(fresh(KIND_SAMPLE));
        send_item(read_at(0, 0));
        send_item(fresh(KIND_SAMPLE));
        settle();

        for (int p = 0; p < 12; p++) begin
            case ($urandom_range(0, 3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = '0;
                default: v = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       d = 16'd0;
                1:       d = 16'd1;
                2:       d = 16'd2;
                3:       d = 16'd3;
                default: d = $urandom_range(4, 9);
            endcase
            if (p == 11)
                calm = 1;
            configure(p[TTYPE_W-1:0], v, d);
            if (p == 2)
                hold_off_req = 1;
            random_phase(14);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d command transactions and checked %0d results.",
                 items_sent, sb.checked);
        $display("Triggers fired %0d times, %0d records stored, %0d full-buffer stops.",
                 sb.trigger_hits, sb.stores, sb.full_stops);
        if (sb.mismatches == 0 && sb.due_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing.", sb.mismatches,
                     sb.due_reports.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/tcb_pkg.sv
sv/triggered_capture_buffer.sv
verif/tb_triggered_capture_buffer.sv
